// File: rtl/core/sfd_pkg.sv
// Shared types, constants and the command classifier for the station frame deframer.
// No dependencies; imported by the parser, output stage, top level and testbench.
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] END_BYTE   = 8'hDD;
  localparam int unsigned HEADER_BYTES = 6;

  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 11'd1024;

  localparam logic RK_DATA   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  // Known command words.
  localparam logic [15:0] CMD_CLOCK     = 16'd527;
  localparam logic [15:0] CMD_ADDRESS   = 16'd1039;
  localparam logic [15:0] CMD_OBS_A     = 16'd8207;
  localparam logic [15:0] CMD_OBS_B     = 16'd1551;
  localparam logic [15:0] CMD_OBS_C     = 16'd9487;
  localparam logic [15:0] CMD_IP_PORT   = 16'd3343;
  localparam logic [15:0] CMD_SENSOR_SW = 16'd2319;
  localparam logic [15:0] CMD_ERROR     = 16'd65039;
  localparam logic [15:0] CMD_CLOSE     = 16'd65295;
  localparam logic [15:0] CMD_HEARTBEAT = 16'd14863;

  localparam logic [3:0] CLS_OTHER     = 4'd0;
  localparam logic [3:0] CLS_CLOCK     = 4'd1;
  localparam logic [3:0] CLS_ADDRESS   = 4'd2;
  localparam logic [3:0] CLS_OBSERVE   = 4'd3;
  localparam logic [3:0] CLS_IP_PORT   = 4'd4;
  localparam logic [3:0] CLS_SENSOR_SW = 4'd5;
  localparam logic [3:0] CLS_ERROR     = 4'd6;
  localparam logic [3:0] CLS_CLOSE     = 4'd7;
  localparam logic [3:0] CLS_HEARTBEAT = 4'd8;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [9:0]  byte_index;
    logic        frame_ok;
    logic [15:0] command;
    logic [3:0]  command_class;
    logic [15:0] source_addr;
    logic [15:0] dest_addr;
    logic [10:0] data_length;
    logic        checksum_ok;
  } result_t;

  function automatic logic [3:0] class_of(input logic [15:0] cmd);
    logic [3:0] cls;
    case (cmd) inside
      CMD_CLOCK:                      cls = CLS_CLOCK;
      CMD_ADDRESS:                    cls = CLS_ADDRESS;
      CMD_OBS_A, CMD_OBS_B, CMD_OBS_C: cls = CLS_OBSERVE;
      CMD_IP_PORT:                    cls = CLS_IP_PORT;
      CMD_SENSOR_SW:                  cls = CLS_SENSOR_SW;
      CMD_ERROR:                      cls = CLS_ERROR;
      CMD_CLOSE:                      cls = CLS_CLOSE;
      CMD_HEARTBEAT:                  cls = CLS_HEARTBEAT;
      default:                        cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sfd_byte_if.sv
// Valid/ready channel carrying one received link byte.
// No dependencies.
`default_nettype none

interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sfd_result_if.sv
// Valid/ready channel carrying one deframer result: a data byte or a frame status.
// No dependencies.
`default_nettype none

interface sfd_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [9:0]  byte_index;
  logic        frame_ok;
  logic [15:0] command;
  logic [3:0]  command_class;
  logic [15:0] source_addr;
  logic [15:0] dest_addr;
  logic [10:0] data_length;
  logic        checksum_ok;

  modport source (
    output valid, output result_kind, output payload_byte, output byte_index,
    output frame_ok, output command, output command_class, output source_addr,
    output dest_addr, output data_length, output checksum_ok,
    input  ready
  );
  modport sink (
    input  valid, input result_kind, input payload_byte, input byte_index,
    input  frame_ok, input command, input command_class, input source_addr,
    input  dest_addr, input data_length, input checksum_ok,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/sfd_parser.sv
// Frame parser: phase state machine, header capture, checksum and result formation.
// Depends on sfd_pkg.
`default_nettype none

module sfd_parser
  import sfd_pkg::*;
#(
  parameter int unsigned MAX_DATA = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             byte_fire,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  output result_t               res
);

  localparam int unsigned LEN_W = $clog2(MAX_DATA + 1);

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_HEADER, PH_DATA, PH_SUM_LO, PH_SUM_HI, PH_END
  } phase_t;

  phase_t           phase;
  logic [CFG_W-1:0] max_data_len;
  logic [7:0]       len_lo;
  logic [LEN_W-1:0] data_len;
  logic [LEN_W-1:0] byte_count;
  logic [15:0]      command_word;
  logic [15:0]      source_word;
  logic [15:0]      dest_word;
  logic [15:0]      running_sum;
  logic [15:0]      received_sum;

  logic [15:0]      total;
  logic [16:0]      limit;
  logic             len_ok;
  logic [LEN_W-1:0] count_inc;
  logic [15:0]      sum_next;
  logic [31:0]      count_ext;
  logic [31:0]      len_ext;
  logic             end_good;

  always_comb begin
    total = {rx_byte, len_lo};
    if ({6'd0, max_data_len} > 17'(MAX_DATA)) begin
      limit = 17'(MAX_DATA);
    end else begin
      limit = {6'd0, max_data_len};
    end
    // Declared length covers the header too, so the data part is total minus the header.
    len_ok = (total >= 16'(HEADER_BYTES)) && ({1'b0, total} <= limit + 17'(HEADER_BYTES));
    count_inc = byte_count + 1'b1;
    sum_next  = running_sum + {8'd0, rx_byte};
    count_ext = 32'(byte_count);
    len_ext   = 32'(data_len);
    end_good  = (rx_byte == END_BYTE);
  end

  always_comb begin
    res = '0;
    res_valid = 1'b0;
    if (phase == PH_DATA) begin
      res_valid        = byte_fire;
      res.result_kind  = RK_DATA;
      res.payload_byte = rx_byte;
      res.byte_index   = count_ext[9:0];
    end else if (phase == PH_END) begin
      res_valid         = byte_fire;
      res.result_kind   = RK_STATUS;
      res.frame_ok      = end_good;
      res.command       = command_word;
      res.command_class = class_of(command_word);
      res.source_addr   = source_word;
      res.dest_addr     = dest_word;
      res.data_length   = len_ext[10:0];
      res.checksum_ok   = end_good && (running_sum == received_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      max_data_len <= MAX_LEN_RESET;
      len_lo       <= '0;
      data_len     <= '0;
      byte_count   <= '0;
      command_word <= '0;
      source_word  <= '0;
      dest_word    <= '0;
      running_sum  <= '0;
      received_sum <= '0;
    end else begin
      if (cfg_we) begin
        max_data_len <= cfg_wdata;
      end
      if (byte_fire) begin
        unique case (phase)
          PH_HUNT: begin
            if (rx_byte == START_BYTE) begin
              phase <= PH_LEN_LO;
            end
          end
          PH_LEN_LO: begin
            len_lo <= rx_byte;
            phase  <= PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if (len_ok) begin
              data_len     <= LEN_W'(total - 16'(HEADER_BYTES));
              byte_count   <= '0;
              running_sum  <= '0;
              command_word <= '0;
              source_word  <= '0;
              dest_word    <= '0;
              phase        <= PH_HEADER;
            end else begin
              phase <= PH_HUNT;
            end
          end
          PH_HEADER: begin
            running_sum <= sum_next;
            case (byte_count[2:0])
              3'd0:    command_word[7:0]  <= rx_byte;
              3'd1:    command_word[15:8] <= rx_byte;
              3'd2:    source_word[7:0]   <= rx_byte;
              3'd3:    source_word[15:8]  <= rx_byte;
              3'd4:    dest_word[7:0]     <= rx_byte;
              default: dest_word[15:8]    <= rx_byte;
            endcase
            if (byte_count == LEN_W'(HEADER_BYTES - 1)) begin
              byte_count <= '0;
              phase      <= (data_len == '0) ? PH_SUM_LO : PH_DATA;
            end else begin
              byte_count <= count_inc;
            end
          end
          PH_DATA: begin
            running_sum <= sum_next;
            byte_count  <= count_inc;
            if (count_inc >= data_len) begin
              phase <= PH_SUM_LO;
            end
          end
          PH_SUM_LO: begin
            received_sum <= {8'd0, rx_byte};
            phase        <= PH_SUM_HI;
          end
          PH_SUM_HI: begin
            received_sum[15:8] <= rx_byte;
            phase              <= PH_END;
          end
          PH_END: begin
            byte_count <= '0;
            phase      <= PH_HUNT;
          end
          default: phase <= PH_HUNT;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sfd_out_buf.sv
// Two-entry output stage: a result register plus a skid register.
// Depends on sfd_pkg.
`default_nettype none

module sfd_out_buf
  import sfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         can_take,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    main_free;

  // The skid entry only fills while the main entry is held, so a free skid
  // means one more result can always be absorbed.
  assign can_take  = !skid_valid;
  assign main_free = !main_valid || out_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/station_frame_deframer.sv
// Station frame deframer top level: byte input channel, result output channel, limit register.
// Depends on sfd_pkg, sfd_byte_if, sfd_result_if, sfd_parser and sfd_out_buf.
//
//   port        direction  width  purpose
//   byte_ch     sink       8      received link bytes, one per transfer
//   result_ch   source     84     data byte results and end-of-frame status
//   cfg_we/     in         1/11   write of the largest accepted data length
//   cfg_wdata
//
// One byte is taken per cycle unless byte_ch stalls; any result it makes is registered.
// The parser state machine updates in the same cycle a byte is taken.
// A two-entry output stage lets byte_ch keep flowing while one result waits;
// byte_ch stalls only when both entries hold results.
// Reset (synchronous) returns to hunting and sets the limit to 1024.
`default_nettype none

module station_frame_deframer
  import sfd_pkg::*;
#(
  parameter int unsigned MAX_DATA = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  sfd_byte_if.sink              byte_ch,
  sfd_result_if.source          result_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic    byte_fire;
  logic    res_valid;
  result_t res;
  logic    can_take;
  result_t out_data;

  assign byte_ch.ready = can_take;
  assign byte_fire     = byte_ch.valid && can_take;

  sfd_parser #(
    .MAX_DATA (MAX_DATA)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_fire (byte_fire),
    .rx_byte   (byte_ch.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_data  (out_data)
  );

  assign result_ch.result_kind   = out_data.result_kind;
  assign result_ch.payload_byte  = out_data.payload_byte;
  assign result_ch.byte_index    = out_data.byte_index;
  assign result_ch.frame_ok      = out_data.frame_ok;
  assign result_ch.command       = out_data.command;
  assign result_ch.command_class = out_data.command_class;
  assign result_ch.source_addr   = out_data.source_addr;
  assign result_ch.dest_addr     = out_data.dest_addr;
  assign result_ch.data_length   = out_data.data_length;
  assign result_ch.checksum_ok   = out_data.checksum_ok;

`ifndef SYNTHESIS
  // Input only stalls when a result is already waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !byte_ch.ready |-> result_ch.valid)
    else $error("byte channel stalled with no result pending");

  // A result is produced only for a byte that was actually transferred.
  a_result_needs_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> byte_fire)
    else $error("result formed without an input transfer");

  // Data results carry no status flags.
  a_data_no_flags: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && (result_ch.result_kind == RK_DATA) |->
      !result_ch.frame_ok && !result_ch.checksum_ok)
    else $error("status flags set on a data result");

  // A matching checksum is never reported for a frame with a bad end byte.
  a_sum_needs_frame: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.checksum_ok |-> result_ch.frame_ok)
    else $error("checksum_ok without frame_ok");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for station_frame_deframer: link byte stream in, data and status out.
// Depends on sfd_pkg, sfd_byte_if, sfd_result_if and station_frame_deframer from the RTL; predicts every result itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam int unsigned DATA_CAP = 1024;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_LIMIT = 100000;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [2:0] {
    P_HUNT, P_LEN_LO, P_LEN_HI, P_HEADER, P_DATA, P_SUM_LO, P_SUM_HI, P_CLOSE
  } parse_phase_e;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  sfd_byte_if   byte_ch ();
  sfd_result_if result_ch ();

  station_frame_deframer #(.MAX_DATA(DATA_CAP)) DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Deframer state as the predictor sees it.
  parse_phase_e     parse_phase;
  logic [15:0]      frame_len;
  logic [10:0]      field_count;
  logic [15:0]      cmd_word;
  logic [15:0]      src_word;
  logic [15:0]      dst_word;
  logic [15:0]      byte_sum;
  logic [15:0]      rx_sum;
  logic [CFG_W-1:0] max_len_reg = MAX_LEN_RESET;

  logic [7:0] link_bytes [$];
  logic [7:0] frame_bytes [$];
  result_t    frame_results_due [$];

  logic [15:0] known_cmds [10] = '{CMD_CLOCK, CMD_ADDRESS, CMD_OBS_A, CMD_OBS_B, CMD_OBS_C,
                                   CMD_IP_PORT, CMD_SENSOR_SW, CMD_ERROR, CMD_CLOSE,
                                   CMD_HEARTBEAT};

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_requests = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;
  int bytes_queued = 0;
  int error_count = 0;

  function automatic int effective_limit();
    return (max_len_reg > DATA_CAP) ? DATA_CAP : int'(max_len_reg);
  endfunction

  function automatic logic [3:0] classify_command(input logic [15:0] cmd);
    case (cmd)
      CMD_CLOCK:                       return CLS_CLOCK;
      CMD_ADDRESS:                     return CLS_ADDRESS;
      CMD_OBS_A, CMD_OBS_B, CMD_OBS_C: return CLS_OBSERVE;
      CMD_IP_PORT:                     return CLS_IP_PORT;
      CMD_SENSOR_SW:                   return CLS_SENSOR_SW;
      CMD_ERROR:                       return CLS_ERROR;
      CMD_CLOSE:                       return CLS_CLOSE;
      CMD_HEARTBEAT:                   return CLS_HEARTBEAT;
      default:                         return CLS_OTHER;
    endcase
  endfunction

  function automatic string describe(input result_t r);
    return $sformatf({"kind=%0d byte=%02h idx=%0d ok=%0b cmd=%04h cls=%0d ",
                      "src=%04h dst=%04h len=%0d sum_ok=%0b"},
                     r.result_kind, r.payload_byte, r.byte_index, r.frame_ok, r.command,
                     r.command_class, r.source_addr, r.dest_addr, r.data_length,
                     r.checksum_ok);
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic reset_predictor();
    parse_phase = P_HUNT;
    frame_len = '0;
    field_count = '0;
    cmd_word = '0;
    src_word = '0;
    dst_word = '0;
    byte_sum = '0;
    rx_sum = '0;
  endtask

  // Advances the predicted parser by one accepted byte and queues any result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    result_t     r;
    logic [15:0] total;
    logic [15:0] data_len;
    r = '0;
    total = {b, frame_len[7:0]};
    data_len = frame_len - 16'(HEADER_BYTES);
    case (parse_phase)
      P_HUNT: begin
        if (b == START_BYTE) parse_phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        frame_len = {8'h00, b};
        parse_phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        if (total < HEADER_BYTES || (total - HEADER_BYTES) > effective_limit()) begin
          frame_len = '0;
          parse_phase = P_HUNT;
        end else begin
          frame_len = total;
          field_count = '0;
          byte_sum = '0;
          cmd_word = '0;
          src_word = '0;
          dst_word = '0;
          parse_phase = P_HEADER;
        end
      end
      P_HEADER: begin
        byte_sum = byte_sum + 16'(b);
        case (field_count)
          11'd0:   cmd_word[7:0] = b;
          11'd1:   cmd_word[15:8] = b;
          11'd2:   src_word[7:0] = b;
          11'd3:   src_word[15:8] = b;
          11'd4:   dst_word[7:0] = b;
          default: dst_word[15:8] = b;
        endcase
        field_count++;
        if (field_count >= HEADER_BYTES) begin
          field_count = '0;
          parse_phase = (data_len == 0) ? P_SUM_LO : P_DATA;
        end
      end
      P_DATA: begin
        byte_sum = byte_sum + 16'(b);
        r.result_kind = RK_DATA;
        r.payload_byte = b;
        r.byte_index = field_count[9:0];
        frame_results_due.push_back(r);
        field_count++;
        if (field_count >= data_len) parse_phase = P_SUM_LO;
      end
      P_SUM_LO: begin
        rx_sum = {8'h00, b};
        parse_phase = P_SUM_HI;
      end
      P_SUM_HI: begin
        rx_sum[15:8] = b;
        parse_phase = P_CLOSE;
      end
      default: begin
        r.result_kind = RK_STATUS;
        r.frame_ok = (b == END_BYTE);
        r.command = cmd_word;
        r.command_class = classify_command(cmd_word);
        r.source_addr = src_word;
        r.dest_addr = dst_word;
        r.data_length = data_len[10:0];
        r.checksum_ok = (b == END_BYTE) && (byte_sum == rx_sum);
        frame_results_due.push_back(r);
        parse_phase = P_HUNT;
        field_count = '0;
      end
    endcase
  endtask

  // Byte source: one transfer per accepted byte, gaps at the configured rate.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
      reset_predictor();
    end else begin
      if (byte_ch.valid && byte_ch.ready) deframe_byte(byte_ch.rx_byte);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (link_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          byte_ch.valid <= 1'b1;
          byte_ch.rx_byte <= link_bytes.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // A long hold-off on the result side, so the output stage fills and stalls the input.
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_requests) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_served <= holdoff_served + 1;
    end
  end

  // Result sink: every transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.result_kind = result_ch.result_kind;
        got.payload_byte = result_ch.payload_byte;
        got.byte_index = result_ch.byte_index;
        got.frame_ok = result_ch.frame_ok;
        got.command = result_ch.command;
        got.command_class = result_ch.command_class;
        got.source_addr = result_ch.source_addr;
        got.dest_addr = result_ch.dest_addr;
        got.data_length = result_ch.data_length;
        got.checksum_ok = result_ch.checksum_ok;
        if (frame_results_due.size() == 0) begin
          note_failure($sformatf("unexpected result: %s", describe(got)));
        end else begin
          want = frame_results_due.pop_front();
          if (got !== want)
            note_failure($sformatf("result mismatch: expected %s, got %s",
                                   describe(want), describe(got)));
        end
      end
      result_ch.ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_frame_prefix(input int keep);
    for (int i = 0; i < keep; i++) push_byte(frame_bytes[i]);
  endtask

  task automatic build_frame(input int dlen, input logic [15:0] cmd, input logic [15:0] src,
                             input logic [15:0] dst, input bit bad_sum, input bit bad_end);
    logic [15:0] total;
    logic [15:0] sum;
    logic [7:0]  hdr [6];
    logic [7:0]  b;
    logic [7:0]  close_byte;
    total = 16'(dlen + HEADER_BYTES);
    sum = '0;
    hdr = '{cmd[7:0], cmd[15:8], src[7:0], src[15:8], dst[7:0], dst[15:8]};
    frame_bytes.delete();
    frame_bytes.push_back(START_BYTE);
    frame_bytes.push_back(total[7:0]);
    frame_bytes.push_back(total[15:8]);
    for (int i = 0; i < 6; i++) begin
      frame_bytes.push_back(hdr[i]);
      sum = sum + 16'(hdr[i]);
    end
    for (int i = 0; i < dlen; i++) begin
      b = 8'($urandom);
      frame_bytes.push_back(b);
      sum = sum + 16'(b);
    end
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    frame_bytes.push_back(sum[7:0]);
    frame_bytes.push_back(sum[15:8]);
    close_byte = END_BYTE;
    if (bad_end) begin
      do close_byte = 8'($urandom); while (close_byte == END_BYTE);
    end
    frame_bytes.push_back(close_byte);
  endtask

  function automatic int pick_length();
    int eff;
    int pick;
    eff = effective_limit();
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, (eff < 8) ? eff : 8);
    if (pick < 90) return $urandom_range(0, (eff < 40) ? eff : 40);
    return (eff <= 64) ? eff : $urandom_range(0, 64);
  endfunction

  function automatic logic [15:0] pick_command();
    if ($urandom_range(0, 99) < 60) return known_cmds[$urandom_range(0, 9)];
    return 16'($urandom);
  endfunction

  // Mostly well-formed frames with random content; the rest is line noise,
  // bad lengths and frames cut short.
  task automatic queue_random_traffic(input int n_bytes);
    int          target;
    int          pick;
    int          over;
    logic [15:0] total;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) begin
      pick = $urandom_range(0, 99);
      over = effective_limit() + HEADER_BYTES + 1;
      if (pick < 70) begin
        build_frame(pick_length(), pick_command(), 16'($urandom), 16'($urandom),
                    $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 10);
        push_frame_prefix(frame_bytes.size());
      end else if (pick < 78) begin
        // Noise is mostly ignored while hunting, so it does not count toward the total.
        repeat ($urandom_range(1, 4)) link_bytes.push_back(8'($urandom));
      end else if (pick < 84) begin
        total = 16'($urandom_range(0, HEADER_BYTES - 1));
        push_byte(START_BYTE);
        push_byte(total[7:0]);
        push_byte(total[15:8]);
      end else if (pick < 90) begin
        total = ($urandom_range(0, 1) != 0) ? 16'(over) : 16'($urandom_range(over, 16'hFFFF));
        push_byte(START_BYTE);
        push_byte(total[7:0]);
        push_byte(total[15:8]);
      end else begin
        build_frame(pick_length(), pick_command(), 16'($urandom), 16'($urandom), 0, 0);
        push_frame_prefix($urandom_range(1, frame_bytes.size() - 1));
      end
    end
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    do begin
      @(negedge clk);
      n++;
    end while ((link_bytes.size() != 0 || byte_ch.valid || frame_results_due.size() != 0)
               && n < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] limit_value, input int idle_pct,
                           input int stall_pct, input int n_bytes);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= limit_value;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len_reg = limit_value;
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random_traffic(n_bytes);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;
    result_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: noise, a short length, an overlong length, an empty frame with
    // extreme header words, and a one-byte frame with a bad closing byte.
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    push_byte(START_BYTE);
    push_byte(8'h05);
    push_byte(8'h00);
    push_byte(START_BYTE);
    push_byte(8'h0B);
    push_byte(8'h04);
    build_frame(0, 16'hFFFF, 16'h0000, 16'hFFFF, 0, 0);
    push_frame_prefix(frame_bytes.size());
    build_frame(1, CMD_HEARTBEAT, 16'hFFFF, 16'h0000, 0, 1);
    push_frame_prefix(frame_bytes.size());

    // Reset limit, no idling: one frame at the largest data length, then a hold-off.
    build_frame(DATA_CAP, pick_command(), 16'($urandom), 16'($urandom), 0, 0);
    push_frame_prefix(frame_bytes.size());
    holdoff_requests <= holdoff_requests + 1;
    queue_random_traffic(60);

    run_phase(11'd0, 51, 0, 70);
    run_phase(11'd2047, 0, 51, 70);
    run_phase(11'd1, 29, 29, 70);
    run_phase(11'd1024, 0, 0, 70);
    run_phase(11'($urandom_range(2, 64)), 29, 29, 70);
    run_phase(11'd1025, 51, 51, 60);
    run_phase(11'd6, 0, 51, 60);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frame_results_due.size() != 0)
      note_failure($sformatf("%0d predicted results never arrived", frame_results_due.size()));
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
